[rtl/lpr_pkg.sv]
// Shared types and constants for the longest prefix route lookup block.
package lpr_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int INDEX_W = 4;
	localparam int ADDR_W = 32;
	localparam int IFACE_W = 3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRES,
		ST_LRES
	} lpr_state_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic scan_en;
		logic load_out;
		logic zero_out;
	} lpr_cmd_t;

	typedef struct packed {
		logic scan_last;
	} lpr_sts_t;

endpackage

[rtl/lpr_ctrl.sv]
// Controller state machine for the route lookup: handshakes, scan sequencing, result slot.
module lpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output lpr_pkg::lpr_cmd_t ctl,
	input  lpr_pkg::lpr_sts_t sts
);
	import lpr_pkg::*;

	lpr_state_t state_q;
	lpr_state_t state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == CMD_LOOKUP) ? ST_SCAN : ST_WRES;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_LRES;
				end
			end
			ST_WRES, ST_LRES: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		ctl = '0;
		ctl.wr_en = accept && (cmd == CMD_WRITE);
		ctl.start = accept && (cmd == CMD_LOOKUP);
		ctl.scan_en = (state_q == ST_SCAN);
		ctl.load_out = ((state_q == ST_WRES) || (state_q == ST_LRES)) && slot_free;
		ctl.zero_out = (state_q == ST_WRES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/lpr_dp.sv]
// Datapath for the route lookup: route table, one-entry-per-cycle comparator, result register.
module lpr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpr_pkg::lpr_cmd_t            ctl,
	output lpr_pkg::lpr_sts_t            sts,
	input  logic [lpr_pkg::INDEX_W-1:0]  entry_index,
	input  logic                         entry_valid,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_prefix,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_mask,
	input  logic [lpr_pkg::IFACE_W-1:0]  entry_iface,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_gateway,
	input  logic [lpr_pkg::ADDR_W-1:0]   lookup_addr,
	output logic                         found,
	output logic [lpr_pkg::INDEX_W-1:0]  match_index,
	output logic [lpr_pkg::IFACE_W-1:0]  out_iface,
	output logic [lpr_pkg::ADDR_W-1:0]   next_hop
);
	import lpr_pkg::*;

	logic [ADDR_W-1:0]  prefix_q  [ENTRIES];
	logic [ADDR_W-1:0]  mask_q    [ENTRIES];
	logic [IFACE_W-1:0] iface_q   [ENTRIES];
	logic [ADDR_W-1:0]  gateway_q [ENTRIES];
	logic [ENTRIES-1:0] active_q;

	logic [ADDR_W-1:0]  addr_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               hit_q;
	logic [ADDR_W-1:0]  best_mask_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [IFACE_W-1:0] best_iface_q;
	logic [ADDR_W-1:0]  best_gw_q;

	logic               found_q;
	logic [INDEX_W-1:0] match_index_q;
	logic [IFACE_W-1:0] out_iface_q;
	logic [ADDR_W-1:0]  next_hop_q;

	logic               slot_ok;
	logic [IDX_W-1:0]   wr_idx;
	logic               match;
	logic               take;
	logic               report;

	// Slots at or beyond the table depth are silently dropped.
	assign slot_ok = (32'(entry_index) < ENTRIES);
	assign wr_idx = IDX_W'(entry_index);

	assign match = active_q[cnt_q] && ((mask_q[cnt_q] & addr_q) == prefix_q[cnt_q]);
	// Equal masks go to the later slot, so the compare is inclusive.
	assign take = match && (!hit_q || (best_mask_q <= mask_q[cnt_q]));
	assign sts.scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
	assign report = hit_q && !ctl.zero_out;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && slot_ok) begin
			prefix_q[wr_idx] <= entry_prefix;
			mask_q[wr_idx] <= entry_mask;
			iface_q[wr_idx] <= entry_iface;
			gateway_q[wr_idx] <= entry_gateway;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			hit_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ctl.wr_en && slot_ok) begin
				active_q[wr_idx] <= entry_valid;
			end
			if (ctl.start) begin
				hit_q <= 1'b0;
				cnt_q <= '0;
			end else if (ctl.scan_en) begin
				cnt_q <= cnt_q + 1'b1;
				if (take) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			addr_q <= lookup_addr;
		end
		if (ctl.scan_en && take) begin
			best_mask_q <= mask_q[cnt_q];
			best_idx_q <= cnt_q;
			best_iface_q <= iface_q[cnt_q];
			best_gw_q <= gateway_q[cnt_q];
		end
		if (ctl.load_out) begin
			found_q <= report;
			match_index_q <= report ? INDEX_W'(best_idx_q) : '0;
			out_iface_q <= report ? best_iface_q : '0;
			next_hop_q <= report ? best_gw_q : '0;
		end
	end

	assign found = found_q;
	assign match_index = match_index_q;
	assign out_iface = out_iface_q;
	assign next_hop = next_hop_q;

endmodule

[rtl/longest_prefix_route_lookup_core.sv]
// Flow: a write request goes from idle to the write result state; a lookup walks the table
// in the scan state and then enters the lookup result state. A result state loads the output
// register, raising out_valid, once no earlier result is pending; no request is taken before
// then. The single comparator visits one of the 16 table slots per cycle during a lookup.
// A pending result sits in an output register, so the next request is taken meanwhile.
// Reset (arst_n low, asynchronous) clears all route active bits, the controller and
// the output valid; stored route fields are not cleared and never match while inactive.
module longest_prefix_route_lookup_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [lpr_pkg::INDEX_W-1:0]  entry_index,
	input  logic                         entry_valid,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_prefix,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_mask,
	input  logic [lpr_pkg::IFACE_W-1:0]  entry_iface,
	input  logic [lpr_pkg::ADDR_W-1:0]   entry_gateway,
	input  logic [lpr_pkg::ADDR_W-1:0]   lookup_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [lpr_pkg::INDEX_W-1:0]  match_index,
	output logic [lpr_pkg::IFACE_W-1:0]  out_iface,
	output logic [lpr_pkg::ADDR_W-1:0]   next_hop
);
	import lpr_pkg::*;

	lpr_cmd_t ctl;
	lpr_sts_t sts;

	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	lpr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.entry_index   (entry_index),
		.entry_valid   (entry_valid),
		.entry_prefix  (entry_prefix),
		.entry_mask    (entry_mask),
		.entry_iface   (entry_iface),
		.entry_gateway (entry_gateway),
		.lookup_addr   (lookup_addr),
		.found         (found),
		.match_index   (match_index),
		.out_iface     (out_iface),
		.next_hop      (next_hop)
	);

endmodule

[rtl/lpr_checker.sv]
// Port-level checker for the route lookup core, bound to the top level.
module lpr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         cmd,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         found,
	input logic [lpr_pkg::INDEX_W-1:0]  match_index,
	input logic [lpr_pkg::IFACE_W-1:0]  out_iface,
	input logic [lpr_pkg::ADDR_W-1:0]   next_hop
);
	import lpr_pkg::*;

	// A result waiting on the consumer must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_index)
			&& $stable(out_iface) && $stable(next_hop))
		else $error("result changed while stalled");

	// A miss or a write reports all-zero route fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_index == '0 && out_iface == '0 && next_hop == '0)
		else $error("nonzero fields on a miss");

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// A lookup keeps the block busy through the whole table walk.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_LOOKUP |=> ##15 !in_ready)
		else $error("lookup finished before the table walk");

endmodule

bind longest_prefix_route_lookup_core lpr_checker u_lpr_checker (.*);
